// ----- src/gwpp_pkg.sv -----
// Package for the 4-bit grayscale window packer.
// Holds command codes, request codes, the job record and the area step codes.
// No dependencies.
`timescale 1ns / 1ps

package gwpp_pkg;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// panel command codes
	localparam logic [7:0] CMD_COLUMN_ADDR = 8'h15;
	localparam logic [7:0] CMD_ROW_ADDR    = 8'h75;

	// one packed pixel
	localparam int NIBBLE_W = 4;
	typedef logic [NIBBLE_W-1:0] nibble_t;

	// request type codes
	localparam logic REQ_AREA  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef enum logic {
		JOB_AREA,
		JOB_PIXEL
	} job_kind_t;

	// bytes of the six-byte address sequence
	typedef enum logic [2:0] {
		STEP_COL_CMD,
		STEP_COL_START,
		STEP_COL_END,
		STEP_ROW_CMD,
		STEP_ROW_START,
		STEP_ROW_END
	} area_step_t;

	// one queued job: area coordinates, or a finished pixel byte in arg_a
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] arg_a;
		logic [7:0] arg_b;
		logic [5:0] arg_c;
		logic [5:0] arg_d;
		logic       flag;	// area: empty window; pixel: area done
	} job_t;

endpackage

// ----- src/gwpp_front.sv -----
// Front part of the window packer: accepts requests, tracks the open area,
// packs pixel nibbles and pushes finished jobs into the queue.
// Depends on gwpp_pkg.
`timescale 1ns / 1ps

module gwpp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [7:0]          x_start,
	input  logic [7:0]          x_end,
	input  logic [5:0]          y_start,
	input  logic [5:0]          y_end,
	input  logic [7:0]          luma,
	input  logic                q_full,
	output logic                push,
	output gwpp_pkg::job_t      push_job
);

	logic [8:0]        width_q;
	logic [6:0]        height_q;
	logic [8:0]        col_q;
	logic [6:0]        row_q;
	gwpp_pkg::nibble_t held_q;
	logic              pend_q;
	logic              open_q;

	logic              accept;
	logic              is_area;
	logic              empty;
	logic [9:0]        col_inc;
	logic              row_end;
	logic [6:0]        row_inc;
	logic              area_fin;
	gwpp_pkg::nibble_t nib;
	logic              emit;
	logic [7:0]        pix_byte;

	// request classification and pixel packing
	always_comb begin
		in_stall = q_full;
		accept   = in_valid && !q_full;
		is_area  = (req_type == gwpp_pkg::REQ_AREA);
		empty    = (x_end < x_start) || (y_end < y_start);
		col_inc  = {1'b0, col_q} + 10'd1;
		row_end  = (col_inc >= {1'b0, width_q});
		row_inc  = row_q + 7'd1;
		area_fin = (row_inc >= height_q);
		nib      = luma[7 -: gwpp_pkg::NIBBLE_W];
		emit     = pend_q || row_end;
		pix_byte = pend_q ? {held_q, nib} : {nib, gwpp_pkg::nibble_t'(0)};
		push     = accept && (is_area || (open_q && emit));
		if (is_area) begin
			push_job.kind  = gwpp_pkg::JOB_AREA;
			push_job.arg_a = x_start;
			push_job.arg_b = x_end;
			push_job.arg_c = y_start;
			push_job.arg_d = y_end;
			push_job.flag  = empty;
		end else begin
			push_job.kind  = gwpp_pkg::JOB_PIXEL;
			push_job.arg_a = pix_byte;
			push_job.arg_b = 8'd0;
			push_job.arg_c = 6'd0;
			push_job.arg_d = 6'd0;
			push_job.flag  = row_end && area_fin;
		end
	end

	// area and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
			pend_q   <= 1'b0;
			open_q   <= 1'b0;
		end else if (accept) begin
			if (is_area) begin
				width_q  <= empty ? 9'd0 : 9'({1'b0, x_end} - {1'b0, x_start} + 9'd1);
				height_q <= empty ? 7'd0 : 7'({1'b0, y_end} - {1'b0, y_start} + 7'd1);
				col_q    <= '0;
				row_q    <= '0;
				held_q   <= '0;
				pend_q   <= 1'b0;
				open_q   <= !empty;
			end else if (open_q) begin
				// hold a high nibble unless it closes the row
				if (!pend_q && !row_end) begin
					held_q <= nib;
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= row_inc;
					if (area_fin) begin
						open_q <= 1'b0;
					end
				end else begin
					col_q <= col_inc[8:0];
				end
			end
		end
	end

endmodule

// ----- src/gwpp_queue.sv -----
// Short job queue between the front and back parts of the window packer.
// Register-based ring buffer; depends on gwpp_pkg for the job record.
`timescale 1ns / 1ps

module gwpp_queue #(
	parameter int DEPTH = gwpp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gwpp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output gwpp_pkg::job_t head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	gwpp_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : AW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : AW'(rd_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= CW'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

// ----- src/gwpp_back.sv -----
// Back part of the window packer: expands queued jobs into output bytes
// and holds them in the output register. Depends on gwpp_pkg.
`timescale 1ns / 1ps

module gwpp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  gwpp_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           is_data,
	output logic           run_last,
	output logic           area_done
);

	gwpp_pkg::area_step_t step_q;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic                 data_q;
	logic                 last_q;
	logic                 done_q;

	logic                 load;
	logic                 is_pix;
	logic [7:0]           nx_byte;
	logic                 nx_data;
	logic                 nx_last;
	logic                 nx_done;

	// byte selection for the current job and step
	always_comb begin
		load   = head_valid && (!out_valid_q || !out_stall);
		is_pix = (head_job.kind == gwpp_pkg::JOB_PIXEL);
		pop    = load && (is_pix || (step_q == gwpp_pkg::STEP_ROW_END));
		nx_byte = 8'd0;
		nx_data = 1'b1;
		nx_last = 1'b0;
		nx_done = 1'b0;
		if (is_pix) begin
			nx_byte = head_job.arg_a;
			nx_last = 1'b1;
			nx_done = head_job.flag;
		end else begin
			unique case (step_q)
				gwpp_pkg::STEP_COL_CMD: begin
					nx_byte = gwpp_pkg::CMD_COLUMN_ADDR;
					nx_data = 1'b0;
				end
				gwpp_pkg::STEP_COL_START: nx_byte = {1'b0, head_job.arg_a[7:1]};
				gwpp_pkg::STEP_COL_END:   nx_byte = {1'b0, head_job.arg_b[7:1]};
				gwpp_pkg::STEP_ROW_CMD: begin
					nx_byte = gwpp_pkg::CMD_ROW_ADDR;
					nx_data = 1'b0;
				end
				gwpp_pkg::STEP_ROW_START: nx_byte = {2'b00, head_job.arg_c};
				gwpp_pkg::STEP_ROW_END: begin
					nx_byte = {2'b00, head_job.arg_d};
					nx_last = 1'b1;
					nx_done = head_job.flag;
				end
				default: begin
					nx_byte = 8'd0;
				end
			endcase
		end
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= gwpp_pkg::STEP_COL_CMD;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (!is_pix) begin
					step_q <= (step_q == gwpp_pkg::STEP_ROW_END) ? gwpp_pkg::STEP_COL_CMD
						: gwpp_pkg::area_step_t'(step_q + 3'd1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nx_byte;
			data_q <= nx_data;
			last_q <= nx_last;
			done_q <= nx_done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign is_data   = data_q;
	assign run_last  = last_q;
	assign area_done = done_q;

endmodule

// ----- src/gray4_window_pixel_packer_unit.sv -----
// Top level of the 4-bit grayscale window packer.
// Instantiates gwpp_front, gwpp_queue and gwpp_back; uses gwpp_pkg.
`timescale 1ns / 1ps

//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid, in_stall | req_type, x_start, x_end, y_start, y_end, luma
//  output  | out_valid, out_stall | out_byte, is_data, run_last, area_done
//
// Pixel requests are taken one per cycle while the queue is not full; the byte a pixel
// completes enters the queue at the accepting edge and moves from the queue head into
// the output register once the jobs ahead of it are out and the output register is free.
// A held high nibble sends nothing. An area request yields six bytes, one per step of the
// back part's step counter; pixels behind it wait in the DEPTH-entry queue.
// in_stall rises only when the queue is full; out_stall freezes the output
// register and the back part, never the front directly.
// Reset clears area state, queue pointers and output valid at once.

module gray4_window_pixel_packer_unit #(
	parameter int DEPTH = gwpp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] x_start,
	input  logic [7:0] x_end,
	input  logic [5:0] y_start,
	input  logic [5:0] y_end,
	input  logic [7:0] luma,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       run_last,
	output logic       area_done
);

	logic           q_full;
	logic           push;
	gwpp_pkg::job_t push_job;
	logic           pop;
	logic           head_valid;
	gwpp_pkg::job_t head_job;

	// request side
	gwpp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.x_start  (x_start),
		.x_end    (x_end),
		.y_start  (y_start),
		.y_end    (y_end),
		.luma     (luma),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	gwpp_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// byte side
	gwpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_data    (is_data),
		.run_last   (run_last),
		.area_done  (area_done)
	);

endmodule

// ----- src/gwpp_checker.sv -----
// Port-level checker for the window packer, bound to the top level.
// Depends on gwpp_pkg for the command codes.
`timescale 1ns / 1ps

module gwpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       run_last,
	input logic       area_done
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_data)
			&& $stable(run_last) && $stable(area_done))
		else $error("stalled output changed");

	// command bytes are only the two address commands, never final
	a_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> (out_byte == gwpp_pkg::CMD_COLUMN_ADDR
			|| out_byte == gwpp_pkg::CMD_ROW_ADDR) && !run_last && !area_done)
		else $error("bad command byte");

	// area completion lands on a final data byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && area_done |-> run_last && is_data)
		else $error("area_done off a final data byte");

	// an unstalled column command is directly followed by a valid data byte
	a_addr_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !is_data && out_byte == gwpp_pkg::CMD_COLUMN_ADDR
			|=> out_valid && is_data)
		else $error("gap in address sequence");

endmodule

bind gray4_window_pixel_packer_unit gwpp_checker u_gwpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.is_data   (is_data),
	.run_last  (run_last),
	.area_done (area_done)
);
